@@ rtl/dqdd_pkg.sv @@
// Shared types and constants of the dual quadrature detent decoder.
package dqdd_pkg;

  localparam int PinW   = 2;
  localparam int CountW = 4;
  localparam int ThrW   = 3;
  localparam int EventW = 3;
  localparam int KnobN  = 2;

  localparam logic [ThrW-1:0] DetentStepsReset = ThrW'(3);

  // Register index on the configuration port.
  localparam logic REG_DETENT_STEPS = 1'b0;

  // Pin phases of one knob, first pin in bit 0.
  localparam logic [PinW-1:0] PHASE_00     = 2'b00;
  localparam logic [PinW-1:0] PHASE_FIRST  = 2'b01;
  localparam logic [PinW-1:0] PHASE_SECOND = 2'b10;
  localparam logic [PinW-1:0] PHASE_DETENT = 2'b11;

  localparam logic signed [CountW-1:0] CountMax = CountW'(7);
  localparam logic signed [CountW-1:0] CountMin = CountW'(-8);

  // Per-knob step report.
  typedef enum logic [1:0] {
    KEV_NONE = 2'd0,
    KEV_UP   = 2'd1,
    KEV_DOWN = 2'd2
  } knob_ev_e;

  // Combined event codes on the result stream.
  localparam logic [EventW-1:0] EVT_NONE       = 3'd0;
  localparam logic [EventW-1:0] EVT_LEFT_UP    = 3'd1;
  localparam logic [EventW-1:0] EVT_LEFT_DOWN  = 3'd2;
  localparam logic [EventW-1:0] EVT_RIGHT_UP   = 3'd3;
  localparam logic [EventW-1:0] EVT_RIGHT_DOWN = 3'd4;

endpackage

@@ rtl/dqdd_knob_lane.sv @@
// One knob lane: previous pins, saturating transition count and detent check.
module dqdd_knob_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [dqdd_pkg::PinW-1:0]     pins_i,
  input  logic [dqdd_pkg::ThrW-1:0]     detent_steps_i,
  output dqdd_pkg::knob_ev_e            event_o
);
  import dqdd_pkg::*;

  logic [PinW-1:0]          prev_q, prev_d;
  logic signed [CountW-1:0] count_q, count_d;
  logic signed [CountW-1:0] thr_pos, thr_neg;
  logic                     old_first;
  logic                     move_up;
  logic                     do_move;

  assign old_first = prev_q[0];
  assign thr_pos   = {1'b0, detent_steps_i};
  assign thr_neg   = -thr_pos;

  always_comb begin
    prev_d  = prev_q;
    count_d = count_q;
    event_o = KEV_NONE;
    do_move = 1'b0;
    move_up = 1'b0;
    if (pins_i != prev_q) begin
      prev_d = pins_i;
      case (pins_i)
        PHASE_00: begin
          do_move = 1'b1;
          move_up = old_first;
        end
        PHASE_FIRST: begin
          do_move = 1'b1;
          move_up = old_first;
        end
        PHASE_SECOND: begin
          do_move = 1'b1;
          move_up = ~old_first;
        end
        default: begin
          // Detent reached: report when the count matches the threshold.
          if (!old_first && count_q == thr_pos) begin
            event_o = KEV_UP;
          end else if (old_first && count_q == thr_neg) begin
            event_o = KEV_DOWN;
          end
          count_d = '0;
        end
      endcase
      if (do_move) begin
        if (move_up && count_q != CountMax) begin
          count_d = count_q + CountW'(1);
        end else if (!move_up && count_q != CountMin) begin
          count_d = count_q - CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      prev_q  <= prev_d;
      count_q <= count_d;
    end
  end

endmodule

@@ rtl/dqdd_merge.sv @@
// Merging stage: combines both lane reports, the left knob has priority.
module dqdd_merge (
  input  dqdd_pkg::knob_ev_e              left_ev_i,
  input  dqdd_pkg::knob_ev_e              right_ev_i,
  output logic [dqdd_pkg::EventW-1:0]     knob_event_o
);
  import dqdd_pkg::*;

  always_comb begin
    case (left_ev_i)
      KEV_UP:   knob_event_o = EVT_LEFT_UP;
      KEV_DOWN: knob_event_o = EVT_LEFT_DOWN;
      default: begin
        case (right_ev_i)
          KEV_UP:   knob_event_o = EVT_RIGHT_UP;
          KEV_DOWN: knob_event_o = EVT_RIGHT_DOWN;
          default:  knob_event_o = EVT_NONE;
        endcase
      end
    endcase
  end

endmodule

@@ rtl/dual_quadrature_detent_decoder_core.sv @@
// Top level of the dual quadrature detent decoder with stream and APB ports.
//
// Channel   Direction  Payload
// s_axis    in         tdata[3:0] encoder_pins, one pin sample per item
// m_axis    out        tdata[2:0] knob_event, one result item per input item
// apb       in/out     register 0 at address 0: detent_steps[2:0]
//
// Both knob lanes update on the accepting edge, and the merged event lands
// in the output register on the same edge.
// An item is accepted whenever the output register is empty or is being
// drained, so a full item per cycle flows while the sink keeps tready high.
// Reset clears the pin history, both counts and the output valid flag, and
// sets detent_steps to 3. A stalled sink holds the result and backs up input.
module dual_quadrature_detent_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream; tdata: [3:0] encoder_pins, [7:4] zero.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // Output stream; tdata: [2:0] knob_event, [7:3] zero.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dqdd_pkg::*;

  logic [ThrW-1:0]   detent_steps_q;
  logic              out_valid_q;
  logic [EventW-1:0] out_event_q;
  logic [EventW-1:0] merged_event;
  logic              in_accept;
  logic              cfg_write;
  logic              reg_sel;
  knob_ev_e          left_ev;
  knob_ev_e          right_ev;

  // The configuration register is selected by word address; an address
  // beyond the single register is ignored on writes and reads as zero.
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[2] == REG_DETENT_STEPS);
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = reg_sel ? {{(32-ThrW){1'b0}}, detent_steps_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detent_steps_q <= DetentStepsReset;
    end else if (cfg_write && reg_sel) begin
      detent_steps_q <= pwdata[ThrW-1:0];
    end
  end

  // The output register parts the two sides, so input keeps flowing while
  // a finished result is taken in the same cycle.
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_accept     = s_axis_tvalid & s_axis_tready;

  // Left knob on pins [1:0], right knob on pins [3:2]; the lanes run in
  // parallel on the same sample.
  dqdd_knob_lane u_left_lane (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .pins_i         (s_axis_tdata[1:0]),
    .detent_steps_i (detent_steps_q),
    .event_o        (left_ev)
  );

  dqdd_knob_lane u_right_lane (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .pins_i         (s_axis_tdata[3:2]),
    .detent_steps_i (detent_steps_q),
    .event_o        (right_ev)
  );

  dqdd_merge u_merge (
    .left_ev_i    (left_ev),
    .right_ev_i   (right_ev),
    .knob_event_o (merged_event)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload register needs no reset; it is only read while valid.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_event_q <= merged_event;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(8-EventW){1'b0}}, out_event_q};

endmodule

@@ tb/dual_quadrature_detent_decoder_core_test.sv @@
// Self-checking testbench for the dual quadrature detent decoder core.
`timescale 1ns / 1ps

module dual_quadrature_detent_decoder_core_test;
  import dqdd_pkg::*;

  // The detent_steps register sits at byte address 0. Address 4 would be the
  // next register index, which the block does not have, so writes there must
  // be dropped.
  localparam logic [2:0] DetentAddr = {REG_DETENT_STEPS, 2'b00};
  localparam logic [2:0] SpareAddr  = 3'd4;

  localparam int IdlePercent = 37;
  localparam int CycleLimit  = 100000;
  localparam int SettleCycles = 16;

  // Pin state and signed transition count of one knob, plus the step that the
  // latest sample reported.
  typedef struct {
    logic [PinW-1:0]          prev;
    logic signed [CountW-1:0] count;
    knob_ev_e                 ev;
  } knob_state_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dual_quadrature_detent_decoder_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state: a private copy of both knobs and of the threshold.
  knob_state_t     left_knob;
  knob_state_t     right_knob;
  logic [ThrW-1:0] detent_model = DetentStepsReset;

  // Pin samples waiting to be driven, and knob events waiting to come out.
  logic [3:0]        pins_pending[$];
  logic [EventW-1:0] knob_events_due[$];

  int  samples_queued = 0;
  int  samples_taken = 0;
  int  events_checked = 0;
  int  step_reports = 0;
  int  settings_used = 0;
  int  errors = 0;
  int  cycle_count = 0;
  bit  pins_taken = 1'b0;
  bit  steady_flow = 1'b0;

  // Random-walk position of each knob along its rotation order, and the way
  // it is currently turning.
  int  knob_pos[2];
  bit  knob_up[2];

  // One knob update. The count moves only on a pin change away from detent;
  // arriving at detent compares the count against the threshold, with the
  // previous first pin telling the direction, and then clears it.
  function automatic knob_state_t advance_knob(knob_state_t k, logic [PinW-1:0] pins);
    knob_state_t nxt;
    int          cnt;
    int          thr;
    logic        up;
    nxt = k;
    nxt.ev = KEV_NONE;
    cnt = k.count;
    thr = int'(detent_model);
    up = 1'b0;
    if (pins == k.prev) begin
      return nxt;
    end
    case (pins)
      PHASE_00, PHASE_FIRST: begin
        up = k.prev[0];
      end
      PHASE_SECOND: begin
        up = !k.prev[0];
      end
      default: begin
        up = 1'b0;
      end
    endcase
    if (pins == PHASE_DETENT) begin
      if (!k.prev[0] && cnt == thr) begin
        nxt.ev = KEV_UP;
      end else if (k.prev[0] && cnt == -thr) begin
        nxt.ev = KEV_DOWN;
      end
      nxt.count = '0;
    end else if (up) begin
      if (k.count != CountMax) nxt.count = k.count + CountW'(1);
    end else begin
      if (k.count != CountMin) nxt.count = k.count - CountW'(1);
    end
    nxt.prev = pins;
    return nxt;
  endfunction

  // Right knob first, left knob second: a left report wins when both knobs
  // reach a step in the same sample.
  function automatic logic [EventW-1:0] decode_sample(logic [3:0] pins);
    logic [EventW-1:0] evt;
    evt = EVT_NONE;
    right_knob = advance_knob(right_knob, pins[3:2]);
    left_knob = advance_knob(left_knob, pins[1:0]);
    if (right_knob.ev == KEV_UP) evt = EVT_RIGHT_UP;
    else if (right_knob.ev == KEV_DOWN) evt = EVT_RIGHT_DOWN;
    if (left_knob.ev == KEV_UP) evt = EVT_LEFT_UP;
    else if (left_knob.ev == KEV_DOWN) evt = EVT_LEFT_DOWN;
    return evt;
  endfunction

  // Pin pair at a position of the clockwise rotation 11, 01, 00, 10.
  function automatic logic [PinW-1:0] phase_at(int pos);
    case (pos)
      0: return PHASE_DETENT;
      1: return PHASE_FIRST;
      2: return PHASE_00;
      default: return PHASE_SECOND;
    endcase
  endfunction

  // Monitor: checks each result item against the oldest expected event and
  // runs the predictor on every pin sample the block accepts.
  always @(posedge clk_i) begin
    logic [EventW-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (knob_events_due.size() == 0) begin
        $display("%0t: result item %0d with no event expected", $time, m_axis_tdata);
        errors++;
      end else begin
        want = knob_events_due.pop_front();
        events_checked++;
        if (want != EVT_NONE) step_reports++;
        if (m_axis_tdata != {5'b0, want}) begin
          $display("%0t: knob event mismatch, expected %0d, got %0d", $time, want,
                   m_axis_tdata);
          errors++;
        end
      end
    end
    pins_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (pins_taken) begin
      knob_events_due.push_back(decode_sample(s_axis_tdata[3:0]));
      samples_taken++;
    end
  end

  // Driver: offers the next pin sample once the current one is taken, and
  // stalls both the source and the sink at random unless steady flow is on.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || pins_taken)) begin
      if (pins_pending.size() != 0 &&
          (steady_flow || $urandom_range(0, 99) >= IdlePercent)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, pins_pending.pop_front()};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst_ni && (steady_flow || $urandom_range(0, 99) >= IdlePercent);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
      $display("** dual_quadrature_detent_decoder_core: FAILED **");
      $finish;
    end
  end

  task automatic queue_pins(logic [3:0] pins);
    pins_pending.push_back(pins);
    samples_queued++;
  endtask

  // Setup cycle, then access cycle; the register takes the value on the edge
  // that ends the access cycle.
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (addr == DetentAddr) detent_model = data[ThrW-1:0];
  endtask

  // Writes a threshold with random upper bits, which the block must ignore.
  task automatic set_detent(logic [ThrW-1:0] steps);
    apb_write(DetentAddr, {29'($urandom_range(0, 32'h1fffffff)), steps});
    settings_used++;
  endtask

  task automatic wait_idle();
    while (samples_taken != samples_queued || knob_events_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Mostly well-formed turning with random direction changes, contact bounce
  // and skipped phases; the rest is raw noise on all four pins.
  task automatic queue_turning(int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 2; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) knob_up[k] = !knob_up[k];
        if (roll < 70) begin
          knob_pos[k] = (knob_pos[k] + (knob_up[k] ? 1 : 3)) % 4;
        end else if (roll < 80) begin
          knob_pos[k] = knob_pos[k];
        end else if (roll < 90) begin
          knob_pos[k] = (knob_pos[k] + (knob_up[k] ? 3 : 1)) % 4;
        end else begin
          knob_pos[k] = $urandom_range(0, 3);
        end
      end
      if ($urandom_range(0, 99) < 15) begin
        queue_pins(4'($urandom_range(0, 15)));
      end else begin
        queue_pins({phase_at(knob_pos[1]), phase_at(knob_pos[0])});
      end
    end
  endtask

  initial begin
    logic [ThrW-1:0] later_steps[6];
    left_knob = '{prev: '0, count: '0, ev: KEV_NONE};
    right_knob = '{prev: '0, count: '0, ev: KEV_NONE};
    knob_pos = '{0, 0};
    knob_up = '{1'b1, 1'b0};
    later_steps = '{3'd0, 3'd1, 3'd7, 3'd2, ThrW'($urandom_range(1, 7)), 3'd5};

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed samples at the reset threshold of three. Left pins are bits
    // 1:0, right pins bits 3:2.
    queue_pins(4'hF);                       // both knobs to detent from 00
    queue_pins(4'hF);                       // unchanged pins
    // Both knobs turn up together; the left report wins.
    queue_pins(4'h5); queue_pins(4'h0); queue_pins(4'hA); queue_pins(4'hF);
    // Right knob one step down.
    queue_pins(4'hB); queue_pins(4'h3); queue_pins(4'h7); queue_pins(4'hF);
    // Left knob one step down.
    queue_pins(4'hE); queue_pins(4'hC); queue_pins(4'hD); queue_pins(4'hF);
    // Right knob one step up.
    queue_pins(4'h7); queue_pins(4'h3); queue_pins(4'hB); queue_pins(4'hF);
    // Left contact bounce keeps the count below the threshold, so the detent is missed.
    for (int n = 0; n < 4; n++) begin
      queue_pins(4'hD);
      queue_pins(4'hC);
    end
    queue_pins(4'hF);
    wait_idle();

    // First random phase at full rate in both directions.
    steady_flow = 1'b1;
    set_detent(3'd3);
    queue_turning(70);
    wait_idle();
    steady_flow = 1'b0;

    // A write to an address with no register behind it must change nothing.
    apb_write(SpareAddr, 32'h5);

    // Further thresholds, including the extremes and zero.
    foreach (later_steps[i]) begin
      set_detent(later_steps[i]);
      queue_turning(55);
      wait_idle();
    end

    repeat (SettleCycles) @(negedge clk_i);

    $display("Checked %0d result items for %0d pin samples; %0d knob steps reported.",
             events_checked, samples_taken, step_reports);
    $display("Thresholds written: %0d, including 0, 1 and 7, with bounce and noise.",
             settings_used);
    if (errors == 0) begin
      $display("** dual_quadrature_detent_decoder_core: PASSED **");
    end else begin
      $display("** dual_quadrature_detent_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ dual_quadrature_detent_decoder_core.f @@
rtl/dqdd_pkg.sv
rtl/dqdd_knob_lane.sv
rtl/dqdd_merge.sv
rtl/dual_quadrature_detent_decoder_core.sv
tb/dual_quadrature_detent_decoder_core_test.sv
